### rtl/pid_sq_pkg.sv
package pid_sq_pkg;

    // shared multiplier: signed 33 x 25 -> 58
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam int ERR_W   = 32;
    localparam int TERM_W  = PROD_W - 16;     // P or D after the Q16 shift
    localparam int ACC_W   = TERM_W + 1;      // P + D
    localparam int INC_W   = PROD_W - 17;     // integral increment
    localparam int DRIVE_W = 25;
    localparam int DUTY_W  = 12;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    typedef enum logic [2:0] {
        REG_PROP_GAIN    = 3'd0,
        REG_INTEG_GAIN   = 3'd1,
        REG_DERIV_GAIN   = 3'd2,
        REG_ADC_ZERO     = 3'd3,
        REG_ADC_SCALE    = 3'd4,
        REG_DRIVE_LIMIT  = 3'd5,
        REG_DUTY_SCALE   = 3'd6,
        REG_HALF_PERIOD  = 3'd7
    } pid_sq_reg_t;

    typedef struct packed {
        logic [23:0] prop_gain;
        logic [23:0] integ_gain_dt;
        logic [23:0] deriv_gain_per_dt;
        logic [11:0] adc_zero;
        logic [23:0] adc_scale;
        logic [23:0] drive_limit;
        logic [7:0]  duty_scale;
        logic [15:0] ref_half_period;
    } pid_sq_cfg_t;

    localparam pid_sq_cfg_t CFG_RESET = '{
        prop_gain:         24'd983040,
        integ_gain_dt:     24'd39322,
        deriv_gain_per_dt: 24'd327680,
        adc_zero:          12'd2048,
        adc_scale:         24'd16388,
        drive_limit:       24'd1638400,
        duty_scale:        8'd6,
        ref_half_period:   16'd100
    };

endpackage

### rtl/pid_sq_mul.sv
module pid_sq_mul (
    input  logic                                   clk,
    input  logic                                   en,
    input  logic signed [pid_sq_pkg::MUL_A_W-1:0]  a,
    input  logic signed [pid_sq_pkg::MUL_B_W-1:0]  b,
    output logic signed [pid_sq_pkg::PROD_W-1:0]   prod
);
    import pid_sq_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule

### rtl/pid_sq_cfg.sv
module pid_sq_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pid_sq_pkg::PADDR_W-1:0]     paddr,
    input  logic [pid_sq_pkg::PDATA_W-1:0]     pwdata,
    output logic [pid_sq_pkg::PDATA_W-1:0]     prdata,
    output logic                               pready,
    output pid_sq_pkg::pid_sq_cfg_t            cfg
);
    import pid_sq_pkg::*;

    pid_sq_cfg_t cfg_reg;
    pid_sq_reg_t reg_idx;

    assign reg_idx = pid_sq_reg_t'(paddr[PADDR_W-1:2]);
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_idx)
                REG_PROP_GAIN:   cfg_reg.prop_gain         <= pwdata[23:0];
                REG_INTEG_GAIN:  cfg_reg.integ_gain_dt     <= pwdata[23:0];
                REG_DERIV_GAIN:  cfg_reg.deriv_gain_per_dt <= pwdata[23:0];
                REG_ADC_ZERO:    cfg_reg.adc_zero          <= pwdata[11:0];
                REG_ADC_SCALE:   cfg_reg.adc_scale         <= pwdata[23:0];
                REG_DRIVE_LIMIT: cfg_reg.drive_limit       <= pwdata[23:0];
                REG_DUTY_SCALE:  cfg_reg.duty_scale        <= pwdata[7:0];
                REG_HALF_PERIOD: cfg_reg.ref_half_period   <= pwdata[15:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_PROP_GAIN:   prdata = {8'd0, cfg_reg.prop_gain};
            REG_INTEG_GAIN:  prdata = {8'd0, cfg_reg.integ_gain_dt};
            REG_DERIV_GAIN:  prdata = {8'd0, cfg_reg.deriv_gain_per_dt};
            REG_ADC_ZERO:    prdata = {20'd0, cfg_reg.adc_zero};
            REG_ADC_SCALE:   prdata = {8'd0, cfg_reg.adc_scale};
            REG_DRIVE_LIMIT: prdata = {8'd0, cfg_reg.drive_limit};
            REG_DUTY_SCALE:  prdata = {24'd0, cfg_reg.duty_scale};
            REG_HALF_PERIOD: prdata = {16'd0, cfg_reg.ref_half_period};
        endcase
    end

endmodule

### rtl/pid_sq_ctrl.sv
module pid_sq_ctrl #(
    parameter int ADC_BITS       = 12,
    parameter int INTEGRAL_WIDTH = 48
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  pid_sq_pkg::pid_sq_cfg_t                 cfg,
    input  logic                                    sample_valid,
    output logic                                    sample_ready,
    input  logic [ADC_BITS-1:0]                     adc_sample,
    output logic                                    result_valid,
    input  logic                                    result_ready,
    output logic [pid_sq_pkg::DUTY_W-1:0]           duty_count,
    output logic signed [pid_sq_pkg::DRIVE_W-1:0]   drive_value,
    output logic                                    drive_clamped,
    output logic                                    reference_high
);
    import pid_sq_pkg::*;

    localparam int DIFF_W  = ((ADC_BITS > 12) ? ADC_BITS : 12) + 1;
    localparam int IW      = INTEGRAL_WIDTH;
    localparam int ISUM_W  = ((IW > INC_W) ? IW : INC_W) + 1;
    localparam int SUM_W   = ((IW > ACC_W) ? IW : ACC_W) + 1;
    localparam int Y_W     = PROD_W - 8;
    localparam int EDIF_W  = Y_W + 1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_Y, ST_E, ST_P, ST_D, ST_I, ST_INT, ST_SUM, ST_DUTY, ST_OUT
    } state_t;

    state_t                    state_reg, state_next;
    logic [ADC_BITS-1:0]       adc_reg;
    logic [16:0]               phase_reg;
    logic                      high_reg;
    logic signed [ERR_W-1:0]   e_reg;
    logic signed [ERR_W-1:0]   last_error_reg;
    logic signed [IW-1:0]      integral_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [DRIVE_W-1:0] u_reg;
    logic                      clamped_reg;
    logic                      result_valid_reg;
    logic [DUTY_W-1:0]         duty_reg;
    logic signed [DRIVE_W-1:0] drive_reg;
    logic                      drive_clamped_reg;
    logic                      ref_high_reg;

    logic                       mul_en;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   prod;

    logic [16:0]                phase_eff;
    logic                       phase_high;
    logic signed [DIFF_W-1:0]   adc_diff;
    logic signed [MUL_A_W-1:0]  e_ext, last_ext;
    logic signed [EDIF_W-1:0]   e_diff;
    logic signed [ERR_W-1:0]    e_sat;
    logic signed [ISUM_W-1:0]   isum;
    logic signed [IW-1:0]       integ_sat;
    logic signed [SUM_W-1:0]    total;
    logic signed [SUM_W-1:0]    lim_pos, lim_neg;
    logic signed [DRIVE_W-1:0]  u_clamp;
    logic                       u_clamped;
    logic [DUTY_W-1:0]          duty_sat;
    logic                       out_free;

    pid_sq_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // reference phase: restart at 2H, high in the second half
    always_comb
    begin
        phase_eff  = (phase_reg >= {cfg.ref_half_period, 1'b0}) ? '0 : phase_reg;
        phase_high = phase_eff >= {1'b0, cfg.ref_half_period};
    end

    assign adc_diff = $signed({{(DIFF_W-ADC_BITS){1'b0}}, adc_reg})
                    - $signed({{(DIFF_W-12){1'b0}}, cfg.adc_zero});
    assign e_ext    = {e_reg[ERR_W-1], e_reg};
    assign last_ext = {last_error_reg[ERR_W-1], last_error_reg};

    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        unique case (state_reg)
            ST_Y:
            begin
                mul_a = {{(MUL_A_W-DIFF_W){adc_diff[DIFF_W-1]}}, adc_diff};
                mul_b = {1'b0, cfg.adc_scale};
            end
            ST_P:
            begin
                mul_a = e_ext;
                mul_b = {1'b0, cfg.prop_gain};
            end
            ST_D:
            begin
                mul_a = e_ext - last_ext;
                mul_b = {1'b0, cfg.deriv_gain_per_dt};
            end
            ST_I:
            begin
                mul_a = e_ext + last_ext;
                mul_b = {1'b0, cfg.integ_gain_dt};
            end
            ST_DUTY:
            begin
                mul_a = {{(MUL_A_W-DRIVE_W){u_reg[DRIVE_W-1]}}, u_reg}
                      + {{(MUL_A_W-24){1'b0}}, cfg.drive_limit};
                mul_b = {{(MUL_B_W-8){1'b0}}, cfg.duty_scale};
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // error: r - y, saturated to 32 bits
    always_comb
    begin
        e_diff = (high_reg ? EDIF_W'(65536) : '0)
               - {prod[PROD_W-1], prod[PROD_W-1:8]};
        if (e_diff[EDIF_W-1:ERR_W-1] == '0 || e_diff[EDIF_W-1:ERR_W-1] == '1)
        begin
            e_sat = e_diff[ERR_W-1:0];
        end
        else
        begin
            e_sat = {e_diff[EDIF_W-1], {(ERR_W-1){~e_diff[EDIF_W-1]}}};
        end
    end

    // trapezoidal integral, saturated to its own width
    always_comb
    begin
        isum = {{(ISUM_W-IW){integral_reg[IW-1]}}, integral_reg}
             + {{(ISUM_W-INC_W){prod[PROD_W-1]}}, prod[PROD_W-1:17]};
        if (isum[ISUM_W-1:IW-1] == '0 || isum[ISUM_W-1:IW-1] == '1)
        begin
            integ_sat = isum[IW-1:0];
        end
        else
        begin
            integ_sat = {isum[ISUM_W-1], {(IW-1){~isum[ISUM_W-1]}}};
        end
    end

    // exact P + D + I, clamped to +-limit
    always_comb
    begin
        total   = {{(SUM_W-ACC_W){acc_reg[ACC_W-1]}}, acc_reg}
                + {{(SUM_W-IW){integral_reg[IW-1]}}, integral_reg};
        lim_pos = {{(SUM_W-24){1'b0}}, cfg.drive_limit};
        lim_neg = -lim_pos;
        priority if (total > lim_pos)
        begin
            u_clamp   = lim_pos[DRIVE_W-1:0];
            u_clamped = 1'b1;
        end
        else if (total < lim_neg)
        begin
            u_clamp   = lim_neg[DRIVE_W-1:0];
            u_clamped = 1'b1;
        end
        else
        begin
            u_clamp   = total[DRIVE_W-1:0];
            u_clamped = 1'b0;
        end
    end

    assign duty_sat = (|prod[PROD_W-1:28]) ? '1 : prod[27:16];
    assign out_free = !result_valid_reg || result_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (sample_valid) state_next = ST_Y;
            ST_Y:    state_next = ST_E;
            ST_E:    state_next = ST_P;
            ST_P:    state_next = ST_D;
            ST_D:    state_next = ST_I;
            ST_I:    state_next = ST_INT;
            ST_INT:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_DUTY;
            ST_DUTY: state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            adc_reg           <= '0;
            phase_reg         <= '0;
            high_reg          <= 1'b0;
            e_reg             <= '0;
            last_error_reg    <= '0;
            integral_reg      <= '0;
            acc_reg           <= '0;
            u_reg             <= '0;
            clamped_reg       <= 1'b0;
            result_valid_reg  <= 1'b0;
            duty_reg          <= '0;
            drive_reg         <= '0;
            drive_clamped_reg <= 1'b0;
            ref_high_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (sample_valid)
                    begin
                        adc_reg   <= adc_sample;
                        high_reg  <= phase_high;
                        phase_reg <= phase_eff + 17'd1;
                    end
                end
                ST_E:   e_reg   <= e_sat;
                ST_D:   acc_reg <= {prod[PROD_W-1], prod[PROD_W-1:16]};
                ST_I:   acc_reg <= acc_reg + {prod[PROD_W-1], prod[PROD_W-1:16]};
                ST_INT:
                begin
                    integral_reg   <= integ_sat;
                    last_error_reg <= e_reg;
                end
                ST_SUM:
                begin
                    u_reg       <= u_clamp;
                    clamped_reg <= u_clamped;
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        duty_reg          <= duty_sat;
                        drive_reg         <= u_reg;
                        drive_clamped_reg <= clamped_reg;
                        ref_high_reg      <= high_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign sample_ready   = (state_reg == ST_IDLE);
    assign result_valid   = result_valid_reg;
    assign duty_count     = duty_reg;
    assign drive_value    = drive_reg;
    assign drive_clamped  = drive_clamped_reg;
    assign reference_high = ref_high_reg;

endmodule

### rtl/pid_square_reference_pwm_unit.sv
// A taken sample runs through ST_Y, ST_E, ST_P, ST_D, ST_I, ST_INT, ST_SUM, ST_DUTY and ST_OUT;
// the single 33x25 multiplier is used five times per sample (scale, P, D, I, duty) under the
// sequencer. result_valid is registered as ST_OUT returns to ST_IDLE, which alone takes samples.
// A result waits in the output register while the next sample is taken; ST_OUT holds until free.
// Reset (rst_n low, asynchronous): registers to defaults, error, integral and
// reference phase cleared, no result pending.
module pid_square_reference_pwm_unit #(
    parameter int ADC_BITS       = 12,
    parameter int INTEGRAL_WIDTH = 48
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [pid_sq_pkg::PADDR_W-1:0]          paddr,
    input  logic [pid_sq_pkg::PDATA_W-1:0]          pwdata,
    output logic [pid_sq_pkg::PDATA_W-1:0]          prdata,
    output logic                                    pready,
    input  logic                                    sample_valid,
    output logic                                    sample_ready,
    input  logic [ADC_BITS-1:0]                     adc_sample,
    output logic                                    result_valid,
    input  logic                                    result_ready,
    output logic [pid_sq_pkg::DUTY_W-1:0]           duty_count,
    output logic signed [pid_sq_pkg::DRIVE_W-1:0]   drive_value,
    output logic                                    drive_clamped,
    output logic                                    reference_high
);
    import pid_sq_pkg::*;

    pid_sq_cfg_t cfg;

    pid_sq_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pid_sq_ctrl #(
        .ADC_BITS       (ADC_BITS),
        .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .sample_valid   (sample_valid),
        .sample_ready   (sample_ready),
        .adc_sample     (adc_sample),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .duty_count     (duty_count),
        .drive_value    (drive_value),
        .drive_clamped  (drive_clamped),
        .reference_high (reference_high)
    );

endmodule

### rtl/pid_sq_checker.sv
module pid_sq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        sample_valid,
    input logic        sample_ready,
    input logic        result_valid,
    input logic        result_ready,
    input logic [11:0] duty_count,
    input logic [24:0] drive_value,
    input logic        drive_clamped
);

    // one sample in work at a time
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && sample_ready) |=> !sample_ready)
        else $error("sample taken while previous one still in work");

    // a fresh result only appears at the end of a full sequence
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(!sample_ready, 1) && $past(!sample_ready, 8))
        else $error("result appeared without a full computation");

    // sequencer hands back to idle only once its result is registered
    a_ready_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sample_ready) |-> result_valid)
        else $error("ready returned without a result");

    // held result stays put
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=>
            result_valid && $stable(duty_count) && $stable(drive_value))
        else $error("stalled result changed");

    // drive clamped at the negative limit maps to zero duty
    a_neg_clamp_duty: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && drive_clamped && drive_value[24]) |-> (duty_count == 12'd0))
        else $error("negative clamp with nonzero duty");

endmodule

bind pid_square_reference_pwm_unit pid_sq_checker u_pid_sq_checker (.*);
